/* hw/rtl/ipv6_flow_key_extractor_assert.svh */
// Assertion macros for the IPv6 flow key extractor.
// IPV6FK_ASSERT checks a property on every rising clock edge outside reset.
// IPV6FK_ASSERT_NEXT checks that a condition implies another in the following cycle.
`ifndef IPV6_FLOW_KEY_EXTRACTOR_ASSERT_SVH
`define IPV6_FLOW_KEY_EXTRACTOR_ASSERT_SVH
`ifndef SYNTH
`define IPV6FK_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ipv6 flow key extractor: assertion failed");
`define IPV6FK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipv6 flow key extractor: assertion failed");
`else
`define IPV6FK_ASSERT(label, clk, rst_n, prop)
`define IPV6FK_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/ipv6fk_pkg.sv */
`default_nettype none
package ipv6fk_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int POS_W       = OFFSET_BITS;

    localparam logic [POS_W-1:0] POS_MAX   = '1;
    localparam logic [POS_W-1:0] FIXED_LEN = POS_W'(40);

    // Byte offsets inside the fixed IPv6 header.
    localparam logic [POS_W-1:0] OFS_NEXT_HDR  = POS_W'(6);
    localparam logic [POS_W-1:0] OFS_ADDR_BEG  = POS_W'(8);
    localparam logic [POS_W-1:0] OFS_FIXED_END = POS_W'(39);

    // Bytes of the upper header needed before a field is reported.
    localparam logic [POS_W-1:0] HDR_MIN_BYTES = POS_W'(2);
    localparam logic [POS_W-1:0] PORT_BYTES    = POS_W'(4);
    localparam logic [POS_W-1:0] MOB_BYTES     = POS_W'(3);
    localparam logic [POS_W-1:0] GRE_BYTES     = POS_W'(12);

    localparam logic [7:0] PROTO_HOPOPT   = 8'd0;
    localparam logic [7:0] PROTO_TCP      = 8'd6;
    localparam logic [7:0] PROTO_UDP      = 8'd17;
    localparam logic [7:0] PROTO_DCCP     = 8'd33;
    localparam logic [7:0] PROTO_ROUTING  = 8'd43;
    localparam logic [7:0] PROTO_FRAGMENT = 8'd44;
    localparam logic [7:0] PROTO_GRE      = 8'd47;
    localparam logic [7:0] PROTO_ICMPV6   = 8'd58;
    localparam logic [7:0] PROTO_DSTOPTS  = 8'd60;
    localparam logic [7:0] PROTO_SCTP     = 8'd132;
    localparam logic [7:0] PROTO_MOBILITY = 8'd135;
    localparam logic [7:0] PROTO_UDPLITE  = 8'd136;

    typedef enum logic [2:0] {
        PH_FIXED = 3'b001,
        PH_WALK  = 3'b010,
        PH_STOP  = 3'b100
    } t_phase;

    function automatic logic is_ext(input logic [7:0] p);
        is_ext = (p == PROTO_HOPOPT) || (p == PROTO_ROUTING) ||
                 (p == PROTO_FRAGMENT) || (p == PROTO_DSTOPTS);
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/ipv6_flow_key_extractor.sv */
`default_nettype none
// IPv6 flow key extractor. Packet bytes enter one per beat on the input channel,
// starting at the fixed IPv6 header; the beat flagged end_of_packet yields one
// flow key on the output channel, and the parser starts over for the next packet.
// A byte is accepted every cycle; the only stall is a last byte that finds the
// result register still full, which holds the input register until the result
// beat is taken. Each byte goes through an input register and one pass of parse
// logic that updates the packet state and, on the last byte, loads the result
// register. mobility_enable (i_cfg_we/i_cfg_wdata) resets to 1; the user must
// write it only while no packet is in progress, which the block does not enforce.
module ipv6_flow_key_extractor (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_packet,
    input  wire logic        i_reverse,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [63:0]      o_src_addr_high,
    output logic [63:0]      o_src_addr_low,
    output logic [63:0]      o_dst_addr_high,
    output logic [63:0]      o_dst_addr_low,
    output logic [7:0]       o_protocol,
    output logic [15:0]      o_src_port,
    output logic [15:0]      o_dst_port,
    output logic [7:0]       o_icmp_type,
    output logic [7:0]       o_icmp_code,
    output logic [31:0]      o_gre_key,
    output logic [7:0]       o_mobility_type
);

    localparam int POS_W = ipv6fk_pkg::POS_W;

    logic r_mob_en;

    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_eop;
    logic       r_in_rev;

    logic [POS_W-1:0]   r_pos, s_pos;
    logic [POS_W-1:0]   r_hs, s_hs;
    logic [7:0]         r_np, s_np;
    ipv6fk_pkg::t_phase r_phase, s_phase;
    logic               r_sup, s_sup;
    logic               r_rev, s_rev;
    logic [255:0]       r_addr, s_addr;
    logic [95:0]        r_upper, s_upper;

    logic             w_go;
    logic             w_take;
    logic [4:0]       w_ai;
    logic [POS_W-1:0] w_k;
    logic [6:0]       w_uidx;
    logic [8:0]       w_len;
    logic [POS_W:0]   w_nxt;
    logic [POS_W:0]   w_diff;

    logic [127:0] w_src, w_dst;
    logic [7:0]   w_proto;
    logic [15:0]  w_sport, w_dport;
    logic [7:0]   w_itype, w_icode;
    logic [31:0]  w_gre;
    logic [7:0]   w_mob;

    // A last byte waits while the result register holds an untaken beat.
    assign w_go       = !r_in_eop || !o_out_valid || i_out_ready;
    assign w_take     = r_in_valid && w_go;
    assign o_in_ready = !r_in_valid || w_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mob_en <= 1'b1;
        end else if (i_cfg_we) begin
            r_mob_en <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_data_byte;
            r_in_eop  <= i_end_of_packet;
            r_in_rev  <= i_reverse;
        end
    end

    // One byte of parsing.
    always_comb begin
        s_pos   = r_pos;
        s_hs    = r_hs;
        s_np    = r_np;
        s_phase = r_phase;
        s_sup   = r_sup;
        s_rev   = r_rev;
        s_addr  = r_addr;
        s_upper = r_upper;
        w_ai    = r_pos[4:0] - 5'd8;
        w_k     = r_pos - r_hs;
        w_uidx  = 7'd95 - {w_k[3:0], 3'b000};
        w_len   = {1'b0, r_in_data} + 9'd1;
        w_nxt   = {1'b0, r_hs} + (POS_W+1)'({w_len, 3'b000});
        if (r_pos != ipv6fk_pkg::POS_MAX) begin
            s_pos = r_pos + POS_W'(1);
            case (r_phase)
                ipv6fk_pkg::PH_FIXED: begin
                    if (r_pos == '0) begin
                        s_rev = r_in_rev;
                    end
                    if (r_pos == ipv6fk_pkg::OFS_NEXT_HDR) begin
                        s_np = r_in_data;
                    end
                    if (r_pos >= ipv6fk_pkg::OFS_ADDR_BEG && r_pos < ipv6fk_pkg::FIXED_LEN) begin
                        s_addr[{~w_ai, 3'b111} -: 8] = r_in_data;
                    end
                    if (r_pos == ipv6fk_pkg::OFS_FIXED_END) begin
                        s_phase = ipv6fk_pkg::PH_WALK;
                        s_hs    = ipv6fk_pkg::FIXED_LEN;
                    end
                end
                ipv6fk_pkg::PH_WALK: begin
                    if (r_pos >= r_hs) begin
                        if (w_k < ipv6fk_pkg::GRE_BYTES) begin
                            s_upper[w_uidx -: 8] = r_in_data;
                        end
                        // Second byte of an extension header holds its length.
                        if (w_k == POS_W'(1) && ipv6fk_pkg::is_ext(r_np)) begin
                            if (r_np == ipv6fk_pkg::PROTO_FRAGMENT) begin
                                s_sup = 1'b1;
                            end
                            if (w_nxt > {1'b0, ipv6fk_pkg::POS_MAX}) begin
                                s_phase = ipv6fk_pkg::PH_STOP;
                            end else begin
                                s_hs = w_nxt[POS_W-1:0];
                                s_np = r_upper[95:88];
                            end
                            s_upper = '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Flow key from the state after the last byte.
    always_comb begin
        w_src   = s_rev ? s_addr[127:0] : s_addr[255:128];
        w_dst   = s_rev ? s_addr[255:128] : s_addr[127:0];
        w_diff  = {1'b0, s_pos} - {1'b0, s_hs};
        w_proto = '0;
        w_sport = '0;
        w_dport = '0;
        w_itype = '0;
        w_icode = '0;
        w_gre   = '0;
        w_mob   = '0;
        if (s_phase == ipv6fk_pkg::PH_WALK && !ipv6fk_pkg::is_ext(s_np) && !w_diff[POS_W] &&
            w_diff[POS_W-1:0] >= ipv6fk_pkg::HDR_MIN_BYTES) begin
            w_proto = s_np;
            if (!s_sup) begin
                if (s_np inside {ipv6fk_pkg::PROTO_TCP, ipv6fk_pkg::PROTO_UDP,
                                 ipv6fk_pkg::PROTO_UDPLITE, ipv6fk_pkg::PROTO_SCTP,
                                 ipv6fk_pkg::PROTO_DCCP}) begin
                    if (w_diff[POS_W-1:0] >= ipv6fk_pkg::PORT_BYTES) begin
                        w_sport = s_rev ? s_upper[79:64] : s_upper[95:80];
                        w_dport = s_rev ? s_upper[95:80] : s_upper[79:64];
                    end
                end else if (s_np == ipv6fk_pkg::PROTO_ICMPV6) begin
                    w_itype = s_upper[95:88];
                    w_icode = s_upper[87:80];
                end else if (s_np == ipv6fk_pkg::PROTO_GRE) begin
                    // Flag word: K is bit 13, C (checksum word present) is bit 15.
                    if (w_diff[POS_W-1:0] >= ipv6fk_pkg::GRE_BYTES && s_upper[93]) begin
                        w_gre = s_upper[95] ? s_upper[31:0] : s_upper[63:32];
                    end
                end else if (s_np == ipv6fk_pkg::PROTO_MOBILITY && r_mob_en) begin
                    if (w_diff[POS_W-1:0] >= ipv6fk_pkg::MOB_BYTES) begin
                        w_mob = s_upper[79:72];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_hs    <= '0;
            r_np    <= '0;
            r_phase <= ipv6fk_pkg::PH_FIXED;
            r_sup   <= 1'b0;
            r_rev   <= 1'b0;
            r_addr  <= '0;
            r_upper <= '0;
        end else if (w_take) begin
            if (r_in_eop) begin
                r_pos   <= '0;
                r_hs    <= '0;
                r_np    <= '0;
                r_phase <= ipv6fk_pkg::PH_FIXED;
                r_sup   <= 1'b0;
                r_rev   <= 1'b0;
                r_addr  <= '0;
                r_upper <= '0;
            end else begin
                r_pos   <= s_pos;
                r_hs    <= s_hs;
                r_np    <= s_np;
                r_phase <= s_phase;
                r_sup   <= s_sup;
                r_rev   <= s_rev;
                r_addr  <= s_addr;
                r_upper <= s_upper;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_take && r_in_eop) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && r_in_eop) begin
            o_src_addr_high <= w_src[127:64];
            o_src_addr_low  <= w_src[63:0];
            o_dst_addr_high <= w_dst[127:64];
            o_dst_addr_low  <= w_dst[63:0];
            o_protocol      <= w_proto;
            o_src_port      <= w_sport;
            o_dst_port      <= w_dport;
            o_icmp_type     <= w_itype;
            o_icmp_code     <= w_icode;
            o_gre_key       <= w_gre;
            o_mobility_type <= w_mob;
        end
    end

`include "ipv6_flow_key_extractor_assert.svh"

    `IPV6FK_ASSERT(a_fixed_hs_zero, i_clk, i_rst_n, (r_phase != ipv6fk_pkg::PH_FIXED) || (r_hs == '0))
    `IPV6FK_ASSERT(a_walk_hs_min, i_clk, i_rst_n, (r_phase != ipv6fk_pkg::PH_WALK) || (r_hs >= ipv6fk_pkg::FIXED_LEN))
    `IPV6FK_ASSERT(a_sup_after_fixed, i_clk, i_rst_n, !r_sup || (r_phase != ipv6fk_pkg::PH_FIXED))
    `IPV6FK_ASSERT_NEXT(a_clear_after_eop, i_clk, i_rst_n, w_take && r_in_eop, (r_pos == '0) && (r_phase == ipv6fk_pkg::PH_FIXED) && o_out_valid)
    `IPV6FK_ASSERT_NEXT(a_eop_waits, i_clk, i_rst_n, r_in_valid && r_in_eop && o_out_valid && !i_out_ready, r_in_valid && r_in_eop)

endmodule
`default_nettype wire

/* tb/ipv6_flow_key_extractor_tb.sv */
`default_nettype none

module ipv6_flow_key_extractor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0]  PROTO_NO_NEXT = 8'd59;
    localparam logic [15:0] GRE_CSUM_BIT  = 16'h8000;
    localparam logic [15:0] GRE_KEY_BIT   = 16'h2000;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    localparam int LONG_HOLD_CYCLES = 400;

    typedef struct {
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
        logic [7:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  icmp_t;
        logic [7:0]  icmp_c;
        logic [31:0] gre_key;
        logic [7:0]  mob_type;
    } t_flow_key;

    // Follows the packet walk byte by byte and queues the flow key that each
    // last byte should produce.
    class t_flow_key_board;
        bit                 mobility_on;
        int unsigned        pos;
        int unsigned        hdr_start;
        logic [7:0]         next_proto;
        ipv6fk_pkg::t_phase phase;
        bit                 frag_seen;
        bit                 rev_latched;
        logic [63:0]        src_w [2];
        logic [63:0]        dst_w [2];
        logic [31:0]        upper_w [3];
        logic [15:0]        gre_flags;
        t_flow_key          pending_keys [$];
        int                 errors;

        function new();
            mobility_on = 1'b1;
            errors      = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            pos         = 0;
            hdr_start   = 0;
            next_proto  = 8'h00;
            phase       = ipv6fk_pkg::PH_FIXED;
            frag_seen   = 1'b0;
            rev_latched = 1'b0;
            src_w       = '{default: '0};
            dst_w       = '{default: '0};
            upper_w     = '{default: '0};
            gre_flags   = 16'h0000;
        endfunction

        function bit chained(logic [7:0] p);
            return p == ipv6fk_pkg::PROTO_HOPOPT || p == ipv6fk_pkg::PROTO_ROUTING ||
                   p == ipv6fk_pkg::PROTO_FRAGMENT || p == ipv6fk_pkg::PROTO_DSTOPTS;
        endfunction

        function void parse_byte(int unsigned idx, logic [7:0] b, bit rev);
            int unsigned i;
            int unsigned k;
            int unsigned nxt;
            if (phase == ipv6fk_pkg::PH_FIXED) begin
                if (idx == 0)
                    rev_latched = rev;
                if (idx == ipv6fk_pkg::OFS_NEXT_HDR)
                    next_proto = b;
                if (idx >= ipv6fk_pkg::OFS_ADDR_BEG && idx < ipv6fk_pkg::FIXED_LEN) begin
                    i = idx - ipv6fk_pkg::OFS_ADDR_BEG;
                    if (i < 16)
                        src_w[i[3]][8*(7 - i[2:0]) +: 8] = b;
                    else
                        dst_w[i[3]][8*(7 - i[2:0]) +: 8] = b;
                end
                if (idx == ipv6fk_pkg::OFS_FIXED_END) begin
                    phase     = ipv6fk_pkg::PH_WALK;
                    hdr_start = ipv6fk_pkg::FIXED_LEN;
                end
                return;
            end
            if (phase != ipv6fk_pkg::PH_WALK || idx < hdr_start)
                return;
            k = idx - hdr_start;
            if (k < 12) begin
                upper_w[k / 4][8*(3 - k % 4) +: 8] = b;
                if (k == 0)
                    gre_flags[15:8] = b;
                if (k == 1)
                    gre_flags[7:0] = b;
            end
            // The second byte of an extension header gives its length, so the walk
            // jumps to the next header (or stops past POS_MAX) and drops what it collected.
            if (k == 1 && chained(next_proto)) begin
                if (next_proto == ipv6fk_pkg::PROTO_FRAGMENT)
                    frag_seen = 1'b1;
                nxt = hdr_start + (int'(b) + 1) * 8;
                if (nxt > ipv6fk_pkg::POS_MAX) begin
                    phase = ipv6fk_pkg::PH_STOP;
                end else begin
                    hdr_start  = nxt;
                    next_proto = upper_w[0][31:24];
                end
                upper_w   = '{default: '0};
                gre_flags = 16'h0000;
            end
        endfunction

        function t_flow_key flow_key();
            t_flow_key   key;
            logic [31:0] w0;
            logic [7:0]  p;
            key = '{default: '0};
            w0  = upper_w[0];
            p   = next_proto;
            key.src_hi = rev_latched ? dst_w[0] : src_w[0];
            key.src_lo = rev_latched ? dst_w[1] : src_w[1];
            key.dst_hi = rev_latched ? src_w[0] : dst_w[0];
            key.dst_lo = rev_latched ? src_w[1] : dst_w[1];
            if (phase != ipv6fk_pkg::PH_WALK || chained(p) ||
                pos < hdr_start + ipv6fk_pkg::HDR_MIN_BYTES)
                return key;
            key.proto = p;
            if (frag_seen)
                return key;
            case (p)
                ipv6fk_pkg::PROTO_TCP, ipv6fk_pkg::PROTO_UDP, ipv6fk_pkg::PROTO_UDPLITE,
                ipv6fk_pkg::PROTO_SCTP, ipv6fk_pkg::PROTO_DCCP: begin
                    if (pos >= hdr_start + ipv6fk_pkg::PORT_BYTES) begin
                        key.sport = rev_latched ? w0[15:0] : w0[31:16];
                        key.dport = rev_latched ? w0[31:16] : w0[15:0];
                    end
                end
                ipv6fk_pkg::PROTO_ICMPV6: begin
                    key.icmp_t = w0[31:24];
                    key.icmp_c = w0[23:16];
                end
                ipv6fk_pkg::PROTO_GRE: begin
                    if (pos >= hdr_start + ipv6fk_pkg::GRE_BYTES &&
                        (gre_flags & GRE_KEY_BIT) != 0)
                        key.gre_key = ((gre_flags & GRE_CSUM_BIT) != 0) ? upper_w[2]
                                                                         : upper_w[1];
                end
                ipv6fk_pkg::PROTO_MOBILITY: begin
                    if (mobility_on && pos >= hdr_start + ipv6fk_pkg::MOB_BYTES)
                        key.mob_type = w0[15:8];
                end
                default: ;
            endcase
            return key;
        endfunction

        function void take_byte(logic [7:0] b, bit eop, bit rev);
            if (pos < ipv6fk_pkg::POS_MAX) begin
                parse_byte(pos, b, rev);
                pos++;
            end
            if (eop) begin
                pending_keys.push_back(flow_key());
                clear_packet();
            end
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                errors++;
                $error("%s: expected %h, got %h", field, want, got);
            end
        endfunction

        function void check_key(t_flow_key got);
            t_flow_key want;
            if (pending_keys.size() == 0) begin
                errors++;
                $error("flow key beat with no packet outstanding");
                return;
            end
            want = pending_keys.pop_front();
            compare("src_addr_high", want.src_hi, got.src_hi);
            compare("src_addr_low", want.src_lo, got.src_lo);
            compare("dst_addr_high", want.dst_hi, got.dst_hi);
            compare("dst_addr_low", want.dst_lo, got.dst_lo);
            compare("protocol", 64'(want.proto), 64'(got.proto));
            compare("src_port", 64'(want.sport), 64'(got.sport));
            compare("dst_port", 64'(want.dport), 64'(got.dport));
            compare("icmp_type", 64'(want.icmp_t), 64'(got.icmp_t));
            compare("icmp_code", 64'(want.icmp_c), 64'(got.icmp_c));
            compare("gre_key", 64'(want.gre_key), 64'(got.gre_key));
            compare("mobility_type", 64'(want.mob_type), 64'(got.mob_type));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_end_of_packet;
    logic        i_reverse;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [63:0] o_src_addr_high;
    logic [63:0] o_src_addr_low;
    logic [63:0] o_dst_addr_high;
    logic [63:0] o_dst_addr_low;
    logic [7:0]  o_protocol;
    logic [15:0] o_src_port;
    logic [15:0] o_dst_port;
    logic [7:0]  o_icmp_type;
    logic [7:0]  o_icmp_code;
    logic [31:0] o_gre_key;
    logic [7:0]  o_mobility_type;

    t_flow_key_board board = new();
    logic [7:0]      pkt [$];
    int              burst_left = 0;
    bit              long_hold_req = 1'b0;

    ipv6_flow_key_extractor u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_end_of_packet (i_end_of_packet),
        .i_reverse       (i_reverse),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_src_addr_high (o_src_addr_high),
        .o_src_addr_low  (o_src_addr_low),
        .o_dst_addr_high (o_dst_addr_high),
        .o_dst_addr_low  (o_dst_addr_low),
        .o_protocol      (o_protocol),
        .o_src_port      (o_src_port),
        .o_dst_port      (o_dst_port),
        .o_icmp_type     (o_icmp_type),
        .o_icmp_code     (o_icmp_code),
        .o_gre_key       (o_gre_key),
        .o_mobility_type (o_mobility_type)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic void payload(input int n);
        repeat (n) pkt.push_back(8'($urandom));
    endfunction

    function automatic void fixed_header(input int fill, input logic [7:0] nh);
        int i;
        pkt = {};
        for (i = 0; i < ipv6fk_pkg::FIXED_LEN; i++) begin
            case (fill)
                FILL_ZERO: pkt.push_back(8'h00);
                FILL_ONES: pkt.push_back(8'hFF);
                default:   pkt.push_back(8'($urandom));
            endcase
        end
        pkt[ipv6fk_pkg::OFS_NEXT_HDR] = nh;
    endfunction

    function automatic void ext_header(input logic [7:0] nh, input logic [7:0] len);
        pkt.push_back(nh);
        pkt.push_back(len);
        payload((int'(len) + 1) * 8 - 2);
    endfunction

    // The sender offers beats in bursts of random length with random gaps.
    task automatic send_byte(input logic [7:0] b, input logic eop, input logic rev);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 256)
                                                     : $urandom_range(1, 16);
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid      <= 1'b1;
        i_data_byte     <= b;
        i_end_of_packet <= eop;
        i_reverse       <= rev;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        board.take_byte(b, eop, rev);
    endtask

    // Only the first byte's reverse flag matters; the rest carry noise.
    task automatic send_packet(input bit rev);
        int i;
        for (i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], i == pkt.size() - 1, (i == 0) ? rev : 1'($urandom));
    endtask

    task automatic upper_packet(input logic [7:0] nh, input int n, input bit rev);
        fixed_header(FILL_RANDOM, nh);
        payload(n);
        send_packet(rev);
    endtask

    task automatic random_packet;
        int         n_ext;
        int         cut;
        int         i;
        int         fill;
        logic [7:0] kinds [4];
        logic [7:0] upper;
        if ($urandom_range(0, 9) == 0) begin
            pkt = {};
            payload($urandom_range(1, 60));
        end else begin
            n_ext = $urandom_range(0, 3);
            for (i = 0; i < 4; i++) begin
                case ($urandom_range(0, 3))
                    0:       kinds[i] = ipv6fk_pkg::PROTO_HOPOPT;
                    1:       kinds[i] = ipv6fk_pkg::PROTO_ROUTING;
                    2:       kinds[i] = ipv6fk_pkg::PROTO_FRAGMENT;
                    default: kinds[i] = ipv6fk_pkg::PROTO_DSTOPTS;
                endcase
            end
            case ($urandom_range(0, 10))
                0:       upper = ipv6fk_pkg::PROTO_TCP;
                1:       upper = ipv6fk_pkg::PROTO_UDP;
                2:       upper = ipv6fk_pkg::PROTO_UDPLITE;
                3:       upper = ipv6fk_pkg::PROTO_SCTP;
                4:       upper = ipv6fk_pkg::PROTO_DCCP;
                5:       upper = ipv6fk_pkg::PROTO_ICMPV6;
                6:       upper = ipv6fk_pkg::PROTO_GRE;
                7:       upper = ipv6fk_pkg::PROTO_MOBILITY;
                8:       upper = PROTO_NO_NEXT;
                default: upper = 8'($urandom);
            endcase
            fill = ($urandom_range(0, 9) == 0) ? $urandom_range(FILL_ZERO, FILL_ONES)
                                               : FILL_RANDOM;
            fixed_header(fill, (n_ext != 0) ? kinds[0] : upper);
            for (i = 0; i < n_ext; i++)
                ext_header((i + 1 < n_ext) ? kinds[i + 1] : upper,
                           ($urandom_range(0, 49) == 0) ? 8'($urandom_range(0, 255))
                                                        : 8'($urandom_range(0, 3)));
            if (upper == ipv6fk_pkg::PROTO_GRE)
                pkt.push_back(8'($urandom) |
                              (($urandom_range(0, 3) != 0) ? GRE_KEY_BIT[15:8] : 8'h00));
            payload($urandom_range(0, 16));
            if ($urandom_range(0, 6) == 0) begin
                cut = $urandom_range(1, pkt.size());
                while (pkt.size() > cut) pkt.pop_back();
            end
        end
        send_packet(1'($urandom));
    endtask

    task automatic random_traffic(input int min_bytes, input int min_packets);
        int bytes_done;
        int packets_done;
        bytes_done   = 0;
        packets_done = 0;
        while (bytes_done < min_bytes || packets_done < min_packets) begin
            random_packet();
            bytes_done += pkt.size();
            packets_done++;
        end
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (board.pending_keys.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_mobility(input bit enable);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= enable;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.mobility_on = enable;
    endtask

    initial begin : rx_stall
        int mode;
        int epoch;
        int hold;
        mode  = 0;
        epoch = 0;
        hold  = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                i_out_ready <= 1'b0;
            end else begin
                if (epoch == 0) begin
                    epoch = $urandom_range(8, 64);
                    mode  = $urandom_range(0, 2);
                end
                epoch--;
                case (mode)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= 1'($urandom);
                    default: i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : key_monitor
        t_flow_key seen;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            seen.src_hi   = o_src_addr_high;
            seen.src_lo   = o_src_addr_low;
            seen.dst_hi   = o_dst_addr_high;
            seen.dst_lo   = o_dst_addr_low;
            seen.proto    = o_protocol;
            seen.sport    = o_src_port;
            seen.dport    = o_dst_port;
            seen.icmp_t   = o_icmp_type;
            seen.icmp_c   = o_icmp_code;
            seen.gre_key  = o_gre_key;
            seen.mob_type = o_mobility_type;
            board.check_key(seen);
        end
    end

    initial begin : stimulus
        int i;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= 1'b0;
        i_in_valid      <= 1'b0;
        i_data_byte     <= 8'h00;
        i_end_of_packet <= 1'b0;
        i_reverse       <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed packets, mobility parsing at its reset value.
        fixed_header(FILL_ONES, ipv6fk_pkg::PROTO_TCP);
        repeat (20) pkt.push_back(8'hFF);
        send_packet(1'b0);
        fixed_header(FILL_ZERO, ipv6fk_pkg::PROTO_TCP);
        payload(20);
        send_packet(1'b1);
        upper_packet(ipv6fk_pkg::PROTO_UDP, 8, 1'b1);
        upper_packet(ipv6fk_pkg::PROTO_UDPLITE, 8, 1'b0);
        upper_packet(ipv6fk_pkg::PROTO_SCTP, 12, 1'b1);
        upper_packet(ipv6fk_pkg::PROTO_DCCP, 16, 1'b0);
        upper_packet(ipv6fk_pkg::PROTO_ICMPV6, 2, 1'b0);
        fixed_header(FILL_RANDOM, ipv6fk_pkg::PROTO_GRE);
        pkt.push_back(GRE_CSUM_BIT[15:8] | GRE_KEY_BIT[15:8]);
        payload(15);
        send_packet(1'b0);
        fixed_header(FILL_RANDOM, ipv6fk_pkg::PROTO_GRE);
        pkt.push_back(GRE_KEY_BIT[15:8]);
        payload(11);
        send_packet(1'b1);
        fixed_header(FILL_RANDOM, ipv6fk_pkg::PROTO_GRE);
        pkt.push_back(8'h00);
        payload(11);
        send_packet(1'b0);
        // GRE key announced but one byte short of the key word.
        fixed_header(FILL_RANDOM, ipv6fk_pkg::PROTO_GRE);
        pkt.push_back(GRE_CSUM_BIT[15:8] | GRE_KEY_BIT[15:8]);
        payload(10);
        send_packet(1'b0);
        upper_packet(ipv6fk_pkg::PROTO_MOBILITY, 8, 1'b0);
        upper_packet(ipv6fk_pkg::PROTO_MOBILITY, 2, 1'b1);
        fixed_header(FILL_RANDOM, ipv6fk_pkg::PROTO_HOPOPT);
        ext_header(ipv6fk_pkg::PROTO_ROUTING, 8'd0);
        ext_header(ipv6fk_pkg::PROTO_DSTOPTS, 8'd1);
        ext_header(ipv6fk_pkg::PROTO_TCP, 8'd2);
        payload(20);
        send_packet(1'b1);
        fixed_header(FILL_RANDOM, ipv6fk_pkg::PROTO_FRAGMENT);
        ext_header(ipv6fk_pkg::PROTO_UDP, 8'd0);
        payload(8);
        send_packet(1'b0);
        upper_packet(PROTO_NO_NEXT, 8, 1'b0);
        upper_packet(ipv6fk_pkg::PROTO_TCP, 3, 1'b0);
        upper_packet(ipv6fk_pkg::PROTO_TCP, 1, 1'b1);
        pkt = {};
        payload(20);
        send_packet(1'b1);
        pkt = {};
        payload(1);
        send_packet(1'b0);
        // Routing header cut off before its end.
        fixed_header(FILL_RANDOM, ipv6fk_pkg::PROTO_ROUTING);
        pkt.push_back(ipv6fk_pkg::PROTO_TCP);
        pkt.push_back(8'd3);
        payload(8);
        send_packet(1'b0);
        drain();

        set_mobility(1'b0);
        upper_packet(ipv6fk_pkg::PROTO_MOBILITY, 8, 1'b1);
        random_traffic(100, 2);
        drain();

        // The receiver holds off for a long stretch while short packets keep
        // coming, so the result register fills and the input stalls.
        set_mobility(1'b1);
        long_hold_req = 1'b1;
        for (i = 0; i < 40; i++) begin
            pkt = {};
            payload($urandom_range(1, 4));
            send_packet(1'($urandom));
        end
        random_traffic(100, 2);
        drain();

        set_mobility(1'b0);
        random_traffic(100, 2);
        drain();

        if (board.errors == 0 && board.pending_keys.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
